>>> design/pearson_correlation_missing_data_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_MISSING_DATA_TOP_DEFINES_SVH
`define PEARSON_CORRELATION_MISSING_DATA_TOP_DEFINES_SVH

// property that holds on every edge out of reset
`define PCMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PCMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pcmd_pkg.sv
// ----------------------------------------------------------------------------
// pcmd_pkg
// Widths, snapshot and handshake types, and sequencer codes for the
// pairwise-complete correlation block.
// ----------------------------------------------------------------------------
package pcmd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 13;
  localparam int LIN_W    = 29;
  localparam int SQ_W     = 43;
  localparam int CROSS_W  = 44;
  localparam int VEC_LEN  = 4096;

  localparam int WORD_W   = 64;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int CHUNK_W  = 16;
  localparam int CHUNKS   = WORD_W / CHUNK_W;
  localparam int CHUNK_CW = $clog2(CHUNKS);

  localparam int SRCH_W   = 144;
  localparam int Q_BITS   = 16;
  localparam int K_W      = $clog2(Q_BITS);
  localparam int R_SHIFT  = 30;

  localparam int CORR_W   = 16;
  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic        [CNT_W-1:0]   n;
    logic signed [LIN_W-1:0]   sa;
    logic signed [LIN_W-1:0]   sb;
    logic        [SQ_W-1:0]    saa;
    logic        [SQ_W-1:0]    sbb;
    logic signed [CROSS_W-1:0] sab;
  } snap_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    OP_N_SAB   = 3'd0,
    OP_SA_SB   = 3'd1,
    OP_N_SAA   = 3'd2,
    OP_SA_SA   = 3'd3,
    OP_N_SBB   = 3'd4,
    OP_SB_SB   = 3'd5,
    OP_D1_D2   = 3'd6,
    OP_NUM_NUM = 3'd7
  } op_t;

endpackage

>>> design/pcmd_front.sv
// ----------------------------------------------------------------------------
// pcmd_front
// Takes one element pair per cycle unless full, drops pairs missing a side and
// accumulates count and sums; on the last pair queues a snapshot and clears.
// ----------------------------------------------------------------------------
module pcmd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [pcmd_pkg::SAMPLE_W-1:0] a_value,
  input  logic signed [pcmd_pkg::SAMPLE_W-1:0] b_value,
  input  logic                                 a_missing,
  input  logic                                 b_missing,
  input  logic                                 last,
  input  logic                                 q_full,
  output logic                                 q_push,
  output pcmd_pkg::snap_t                      q_data
);

  logic        [pcmd_pkg::CNT_W-1:0]      n;
  logic signed [pcmd_pkg::LIN_W-1:0]      sa;
  logic signed [pcmd_pkg::LIN_W-1:0]      sb;
  logic        [pcmd_pkg::SQ_W-1:0]       saa;
  logic        [pcmd_pkg::SQ_W-1:0]       sbb;
  logic signed [pcmd_pkg::CROSS_W-1:0]    sab;
  logic signed [2*pcmd_pkg::SAMPLE_W-1:0] aa;
  logic signed [2*pcmd_pkg::SAMPLE_W-1:0] bb;
  logic signed [2*pcmd_pkg::SAMPLE_W-1:0] ab;
  logic                                   take;
  logic                                   accept;
  pcmd_pkg::snap_t                        sums_next;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && last;
  assign q_data = sums_next;

  assign aa = a_value * a_value;
  assign bb = b_value * b_value;
  assign ab = a_value * b_value;

  always_comb begin
    take = !a_missing && !b_missing && (n < pcmd_pkg::CNT_W'(pcmd_pkg::VEC_LEN));
    sums_next.n   = n;
    sums_next.sa  = sa;
    sums_next.sb  = sb;
    sums_next.saa = saa;
    sums_next.sbb = sbb;
    sums_next.sab = sab;
    if (take) begin
      sums_next.n   = n + pcmd_pkg::CNT_W'(1);
      sums_next.sa  = sa + pcmd_pkg::LIN_W'(a_value);
      sums_next.sb  = sb + pcmd_pkg::LIN_W'(b_value);
      sums_next.saa = saa + pcmd_pkg::SQ_W'(aa);
      sums_next.sbb = sbb + pcmd_pkg::SQ_W'(bb);
      sums_next.sab = sab + pcmd_pkg::CROSS_W'(ab);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      n   <= '0;
      sa  <= '0;
      sb  <= '0;
      saa <= '0;
      sbb <= '0;
      sab <= '0;
    end else if (accept) begin
      n   <= sums_next.n;
      sa  <= sums_next.sa;
      sb  <= sums_next.sb;
      saa <= sums_next.saa;
      sbb <= sums_next.sbb;
      sab <= sums_next.sab;
    end
  end

endmodule

>>> design/pcmd_queue.sv
// ----------------------------------------------------------------------------
// pcmd_queue
// Short snapshot queue between front and back; read data is registered on pop.
// ----------------------------------------------------------------------------
module pcmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  pcmd_pkg::snap_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output pcmd_pkg::snap_t rd_data,
  output logic            empty
);

  pcmd_pkg::snap_t                mem [pcmd_pkg::Q_DEPTH];
  logic [pcmd_pkg::QPTR_W-1:0]    wptr;
  logic [pcmd_pkg::QPTR_W-1:0]    rptr;
  logic [pcmd_pkg::QCNT_W-1:0]    count;

  assign full  = (count == pcmd_pkg::QCNT_W'(pcmd_pkg::Q_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + pcmd_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rptr <= rptr + pcmd_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + pcmd_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - pcmd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> design/pcmd_mul.sv
// ----------------------------------------------------------------------------
// pcmd_mul
// Shared signed 64x64 multiplier, one 16-bit digit of the second operand
// per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module pcmd_mul (
  input  logic               clk,
  input  logic               rst,
  input  pcmd_pkg::mul_req_t req,
  output pcmd_pkg::mul_rsp_t rsp
);

  logic [pcmd_pkg::WORD_W-1:0]                    amag;
  logic [pcmd_pkg::WORD_W-1:0]                    bmag;
  logic                                           neg;
  logic [pcmd_pkg::CHUNK_CW-1:0]                  cnt;
  logic                                           busy;
  logic                                           done;
  logic [pcmd_pkg::PROD_W-1:0]                    acc;
  logic [pcmd_pkg::WORD_W+pcmd_pkg::CHUNK_W-1:0]  part;
  logic [pcmd_pkg::WORD_W-1:0]                    a_abs;
  logic [pcmd_pkg::WORD_W-1:0]                    b_abs;

  assign a_abs = req.a[pcmd_pkg::WORD_W-1] ? -req.a : req.a;
  assign b_abs = req.b[pcmd_pkg::WORD_W-1] ? -req.b : req.b;
  assign part  = amag * bmag[pcmd_pkg::WORD_W-1 -: pcmd_pkg::CHUNK_W];

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = neg ? -acc : acc;

  always_ff @(posedge clk) begin
    if (req.start) begin
      amag <= a_abs;
      bmag <= b_abs;
      neg  <= req.a[pcmd_pkg::WORD_W-1] ^ req.b[pcmd_pkg::WORD_W-1];
      acc  <= '0;
    end else if (busy) begin
      acc  <= (acc << pcmd_pkg::CHUNK_W) + pcmd_pkg::PROD_W'(part);
      bmag <= bmag << pcmd_pkg::CHUNK_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + pcmd_pkg::CHUNK_CW'(1);
        if (cnt == pcmd_pkg::CHUNK_CW'(pcmd_pkg::CHUNKS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/pcmd_back.sv
// ----------------------------------------------------------------------------
// pcmd_back
// Forms numerator and denominator terms on the shared multiplier, then finds
// the Q1.15 magnitude bit by bit in S_SUM/S_CMP and holds the result for pop.
// ----------------------------------------------------------------------------
`include "pearson_correlation_missing_data_top_defines.svh"

module pcmd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  pcmd_pkg::snap_t                    q_rd_data,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [pcmd_pkg::CORR_W-1:0] correlation,
  output logic        [pcmd_pkg::CNT_W-1:0]  pair_count,
  output logic                               degenerate
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_MUL   = 6'b000100,
    S_SUM   = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                              st;
  pcmd_pkg::op_t                       op;
  pcmd_pkg::mul_req_t                  mul_req;
  pcmd_pkg::mul_rsp_t                  mul_rsp;
  logic signed [pcmd_pkg::WORD_W-1:0]  t0;
  logic signed [pcmd_pkg::WORD_W-1:0]  num;
  logic signed [pcmd_pkg::WORD_W-1:0]  d1;
  logic signed [pcmd_pkg::WORD_W-1:0]  d2;
  logic signed [pcmd_pkg::WORD_W-1:0]  mag;
  logic signed [pcmd_pkg::WORD_W-1:0]  diff;
  logic [pcmd_pkg::PROD_W-1:0]         dd;
  logic [pcmd_pkg::SRCH_W-1:0]         rr;
  logic [pcmd_pkg::SRCH_W-1:0]         pp;
  logic [pcmd_pkg::SRCH_W-1:0]         ee;
  logic [pcmd_pkg::SRCH_W-1:0]         ff;
  logic [pcmd_pkg::SRCH_W-1:0]         trial;
  logic [pcmd_pkg::Q_BITS-1:0]         qv;
  logic [pcmd_pkg::Q_BITS-1:0]         q_now;
  logic [pcmd_pkg::K_W-1:0]            k;
  logic                                fit;
  logic [pcmd_pkg::CORR_W-1:0]         corr_fin;

  pcmd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign q_pop = (st == S_IDLE) && !q_empty;
  assign empty = (st != S_DONE);
  assign mag   = num[pcmd_pkg::WORD_W-1] ? -num : num;
  assign diff  = t0 - mul_rsp.product[pcmd_pkg::WORD_W-1:0];
  assign fit   = (trial <= rr);

  always_comb begin
    mul_req.start = (st == S_ISSUE);
    case (op)
      pcmd_pkg::OP_N_SAB: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.n);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.sab);
      end
      pcmd_pkg::OP_SA_SB: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.sa);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.sb);
      end
      pcmd_pkg::OP_N_SAA: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.n);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.saa);
      end
      pcmd_pkg::OP_SA_SA: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.sa);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.sa);
      end
      pcmd_pkg::OP_N_SBB: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.n);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.sbb);
      end
      pcmd_pkg::OP_SB_SB: begin
        mul_req.a = pcmd_pkg::WORD_W'(q_rd_data.sb);
        mul_req.b = pcmd_pkg::WORD_W'(q_rd_data.sb);
      end
      pcmd_pkg::OP_D1_D2: begin
        mul_req.a = d1;
        mul_req.b = d2;
      end
      pcmd_pkg::OP_NUM_NUM: begin
        mul_req.a = mag;
        mul_req.b = mag;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    q_now = qv;
    if (fit) begin
      q_now[k] = 1'b1;
    end
    if (num[pcmd_pkg::WORD_W-1]) begin
      corr_fin = q_now[pcmd_pkg::Q_BITS-1] ? pcmd_pkg::CORR_MIN
                                           : -pcmd_pkg::CORR_W'(q_now);
    end else begin
      corr_fin = q_now[pcmd_pkg::Q_BITS-1] ? pcmd_pkg::CORR_MAX
                                           : pcmd_pkg::CORR_W'(q_now);
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_MUL: begin
        if (mul_rsp.done) begin
          case (op)
            pcmd_pkg::OP_N_SAB, pcmd_pkg::OP_N_SAA, pcmd_pkg::OP_N_SBB: begin
              t0 <= mul_rsp.product[pcmd_pkg::WORD_W-1:0];
            end
            pcmd_pkg::OP_SA_SB: begin
              num <= diff;
            end
            pcmd_pkg::OP_SA_SA: begin
              d1 <= diff;
            end
            pcmd_pkg::OP_SB_SB: begin
              d2          <= diff;
              pair_count  <= q_rd_data.n;
              correlation <= '0;
              degenerate  <= (d1 <= 0) || (diff <= 0);
            end
            pcmd_pkg::OP_D1_D2: begin
              dd <= mul_rsp.product;
            end
            pcmd_pkg::OP_NUM_NUM: begin
              rr <= pcmd_pkg::SRCH_W'(mul_rsp.product) << pcmd_pkg::R_SHIFT;
              pp <= '0;
              ee <= '0;
              ff <= pcmd_pkg::SRCH_W'(dd) << (2 * (pcmd_pkg::Q_BITS - 1));
              qv <= '0;
            end
            default: begin
              t0 <= t0;
            end
          endcase
        end
      end
      S_SUM: begin
        trial <= pp + ee + ff;
      end
      S_CMP: begin
        if (fit) begin
          pp    <= trial;
          ee    <= (ee + (ff << 1)) >> 1;
          qv[k] <= 1'b1;
        end else begin
          ee <= ee >> 1;
        end
        ff <= ff >> 2;
        if (k == '0) begin
          correlation <= corr_fin;
        end
      end
      default: begin
        trial <= trial;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      op <= pcmd_pkg::OP_N_SAB;
      k  <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (!q_empty) begin
            st <= S_ISSUE;
            op <= pcmd_pkg::OP_N_SAB;
          end
        end
        S_ISSUE: begin
          st <= S_MUL;
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            op <= pcmd_pkg::op_t'(op + 3'd1);
            if (op == pcmd_pkg::OP_NUM_NUM) begin
              st <= S_SUM;
              k  <= pcmd_pkg::K_W'(pcmd_pkg::Q_BITS - 1);
            end else if (op == pcmd_pkg::OP_SB_SB && ((d1 <= 0) || (diff <= 0))) begin
              st <= S_DONE;
            end else begin
              st <= S_ISSUE;
            end
          end
        end
        S_SUM: begin
          st <= S_CMP;
        end
        S_CMP: begin
          if (k == '0) begin
            st <= S_DONE;
          end else begin
            k  <= k - pcmd_pkg::K_W'(1);
            st <= S_SUM;
          end
        end
        S_DONE: begin
          if (pop) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `PCMD_ASSERT(a_pop_nonempty, (q_pop |-> !q_empty), "snapshot pop while queue empty")
  `PCMD_ASSERT(a_start_free, (mul_req.start |-> !mul_rsp.busy), "multiplier restarted while busy")
  `PCMD_ASSERT_NEXT(a_hold_result, (st == S_DONE) && !pop, st == S_DONE, "result dropped unpopped")

endmodule

>>> design/pearson_correlation_missing_data_top.sv
// Throughput: one element pair per cycle into the accumulators while full is low;
// the back end works on one vector pair at a time (eight 64x64 products, then a
// 16-step bit search; less when degenerate). Two snapshots may queue.
// Reset: synchronous rst clears sums, queue and sequencer; no result pending.
// ----------------------------------------------------------------------------
// pearson_correlation_missing_data_top
// Pairwise-complete Pearson correlation of two streamed vectors, Q1.15 out.
// ----------------------------------------------------------------------------
module pearson_correlation_missing_data_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [pcmd_pkg::SAMPLE_W-1:0] a_value,
  input  logic signed [pcmd_pkg::SAMPLE_W-1:0] b_value,
  input  logic                                 a_missing,
  input  logic                                 b_missing,
  input  logic                                 last,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [pcmd_pkg::CORR_W-1:0]   correlation,
  output logic        [pcmd_pkg::CNT_W-1:0]    pair_count,
  output logic                                 degenerate
);

  pcmd_pkg::snap_t q_wr_data;
  pcmd_pkg::snap_t q_rd_data;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  pcmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .a_value   (a_value),
    .b_value   (b_value),
    .a_missing (a_missing),
    .b_missing (b_missing),
    .last      (last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  pcmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  pcmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rd_data   (q_rd_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .correlation (correlation),
    .pair_count  (pair_count),
    .degenerate  (degenerate)
  );

endmodule

>>> verif/pearson_correlation_missing_data_top_tb.sv
// ----------------------------------------------------------------------------
// Pairwise-complete correlation testbench
// Streams element pairs with missing flags into the block and predicts every
// Q1.15 coefficient with exact wide-integer arithmetic. A scoreboard compares
// each popped result against the oldest prediction. Both handshakes stall at
// random, and one vector runs past the accumulator length.
// ----------------------------------------------------------------------------
typedef struct {
  logic signed [pcmd_pkg::CORR_W-1:0] corr;
  logic        [pcmd_pkg::CNT_W-1:0]  cnt;
  logic                               deg;
} corr_result_t;

class corr_scoreboard;
  longint       n, sa, sb, saa, sbb, sab;
  corr_result_t pending[$];
  int           errors;
  int           results_seen;
  int           degenerate_seen;

  function new();
    n = 0; sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
    errors = 0; results_seen = 0; degenerate_seen = 0;
  endfunction

  function void note_request(logic signed [15:0] a, logic signed [15:0] b,
                             logic am, logic bm, logic lst);
    longint       av, bv, num, d1, d2;
    logic [191:0] mag, rhs, den, lhs, mid;
    logic [191:0] lo, hi;
    corr_result_t r;
    av = a;
    bv = b;
    if (!am && !bm && n < pcmd_pkg::VEC_LEN) begin
      n++;
      sa += av; sb += bv;
      saa += av * av; sbb += bv * bv; sab += av * bv;
    end
    if (!lst) return;
    num = n * sab - sa * sb;
    d1 = n * saa - sa * sa;
    d2 = n * sbb - sb * sb;
    r.cnt = n[12:0];
    if (d1 <= 0 || d2 <= 0) begin
      r.corr = '0;
      r.deg = 1'b1;
    end else begin
      mag = (num < 0) ? 192'(-num) : 192'(num);
      rhs = (mag * mag) << pcmd_pkg::R_SHIFT;
      den = 192'(d1) * 192'(d2);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = (mid * mid) * den;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (num < 0) r.corr = -lo[15:0];
      else r.corr = (lo > 32767) ? 16'sd32767 : lo[15:0];
      r.deg = 1'b0;
    end
    pending.push_back(r);
    n = 0; sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
  endfunction

  function void check_result(logic signed [15:0] corr, logic [12:0] cnt, logic deg);
    corr_result_t e;
    results_seen++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result corr=%0d cnt=%0d deg=%0b", corr, cnt, deg);
      return;
    end
    e = pending.pop_front();
    if (deg) degenerate_seen++;
    if (e.corr !== corr || e.cnt !== cnt || e.deg !== deg) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected corr=%0d cnt=%0d deg=%0b, got corr=%0d cnt=%0d deg=%0b",
                 e.corr, e.cnt, e.deg, corr, cnt, deg);
    end
  endfunction
endclass

module pearson_correlation_missing_data_top_tb;

  localparam int LIMIT = 2000000;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 push = 1'b0;
  logic                                 full;
  logic signed [pcmd_pkg::SAMPLE_W-1:0] a_value = '0;
  logic signed [pcmd_pkg::SAMPLE_W-1:0] b_value = '0;
  logic                                 a_missing = 1'b0;
  logic                                 b_missing = 1'b0;
  logic                                 last = 1'b0;
  logic                                 empty;
  logic                                 pop = 1'b0;
  logic signed [pcmd_pkg::CORR_W-1:0]   correlation;
  logic        [pcmd_pkg::CNT_W-1:0]    pair_count;
  logic                                 degenerate;

  corr_scoreboard sb = new();
  int             cycles = 0;
  int             items_sent = 0;
  bit             pop_enable = 1'b0;

  pearson_correlation_missing_data_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a_value(a_value), .b_value(b_value), .a_missing(a_missing),
    .b_missing(b_missing), .last(last), .empty(empty), .pop(pop),
    .correlation(correlation), .pair_count(pair_count), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (!rst) begin
      if (push && !full) sb.note_request(a_value, b_value, a_missing, b_missing, last);
      if (pop && !empty) sb.check_result(correlation, pair_count, degenerate);
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (!pop_enable) pop = 1'b0;
      else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if ($urandom_range(99) < 20) stall = gap_len();
      end
    end
  end

  task automatic send(logic signed [15:0] a, logic signed [15:0] b,
                      logic am, logic bm, logic lst, bit gaps);
    int g;
    @(negedge clk);
    a_value = a; b_value = b; a_missing = am; b_missing = bm; last = lst;
    push = 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32)) - 16);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  initial begin
    int                 len, kind, corr_mode, miss_pct;
    logic signed [15:0] a, b;
    logic               am, bm;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    pop_enable = 1'b1;

    // directed
    send(16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    send(16'sh8000, 16'sh8000, 0, 0, 0, 0);
    send(16'sh0000, 16'sh0000, 0, 0, 1, 0);
    send(16'sh7fff, 16'sh8000, 0, 0, 0, 0);
    send(16'sh8000, 16'sh7fff, 0, 0, 0, 0);
    send(16'sh1234, 16'sh0001, 0, 0, 1, 0);
    send(16'sh0005, 16'sh0005, 0, 0, 1, 0);
    send(16'sh0005, 16'sh0005, 1, 0, 1, 0);
    send(16'sh0005, 16'sh0005, 0, 1, 0, 0);
    send(16'sh0006, 16'sh0006, 1, 1, 1, 0);
    send(16'sh0001, 16'sh0001, 0, 0, 0, 0);
    send(16'sh7fff, 16'sh7fff, 1, 0, 0, 0);
    send(16'sh0002, 16'sh0003, 0, 0, 0, 0);
    send(16'sh0003, 16'sh0005, 0, 0, 1, 0);
    send(16'sh0001, 16'shffff, 0, 0, 0, 0);
    send(16'sh0004, 16'shfffc, 0, 0, 0, 0);
    send(16'sh8000, 16'sh7fff, 0, 0, 1, 0);
    send(16'sh0007, 16'sh0001, 0, 0, 0, 0);
    send(16'sh0007, 16'sh0002, 0, 0, 1, 0);
    send(16'sh7fff, 16'sh0001, 0, 0, 0, 0);
    send(16'sh8000, 16'sh7ffe, 0, 0, 1, 0);

    // hold off until every result has arrived
    drain();

    // overlong vector: pairs past the accumulator length are dropped
    for (int i = 0; i < pcmd_pkg::VEC_LEN + 6; i++)
      send(16'($urandom), 16'($urandom), 0, 0, i == pcmd_pkg::VEC_LEN + 5, 0);

    // random vectors
    while (items_sent < 450 + pcmd_pkg::VEC_LEN + 27) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(16, 1) : $urandom_range(60, 17);
      kind = $urandom_range(9) < 7 ? 0 : $urandom_range(2, 1);
      corr_mode = $urandom_range(3);
      miss_pct = ($urandom_range(3) == 0) ? 60 : 10;
      for (int i = 0; i < len; i++) begin
        a = rand_sample(kind);
        case (corr_mode)
          0: b = rand_sample(kind);
          1: b = a;
          2: b = -a;
          default: b = a + 16'($signed($urandom_range(64)) - 32);
        endcase
        am = $urandom_range(99) < miss_pct;
        bm = $urandom_range(99) < miss_pct;
        send(a, b, am, bm, (i == len - 1) || ($urandom_range(99) == 0), 1);
      end
    end

    drain();
    repeat (300) @(negedge clk);
    $display("sent %0d pairs, checked %0d coefficients (%0d degenerate)",
             items_sent, sb.results_seen, sb.degenerate_seen);
    $display("mismatches: %0d, left over: %0d", sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
